@@ src/hnm_pkg.sv @@
// ----------------------------------------------------------------------------
// Height to normal map package
// Shared widths, register indexes, controller states, command and status
// structs, and the coverage to height function used to build the height table.
// ----------------------------------------------------------------------------
package hnm_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COV_W      = 8;
    localparam int NRM_W      = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 12;
    localparam int STEEP_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int OP_W   = 30;
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int U_W    = 32;
    localparam int DIV_W  = 41;
    localparam int Q_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEEPNESS    = 2'd2;

    localparam logic [WIDTH_W-1:0] WIDTH_RST  = 12'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd1024;
    localparam logic [STEEP_W-1:0] STEEP_RST  = 16'd256;

    localparam logic [1:0] EMIT_UP_A   = 2'd0;
    localparam logic [1:0] EMIT_UP_B   = 2'd1;
    localparam logic [1:0] EMIT_LAST_A = 2'd2;
    localparam logic [1:0] EMIT_LAST_B = 2'd3;

    localparam logic [63:0] NormLimit  = 64'd1 << OP_W;
    localparam logic [63:0] HeightDen  = 64'd16581375;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_WR0,
        ST_WR1,
        ST_PICK,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIVI,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       rd0;
        logic       rd1;
        logic       cap0;
        logic       cap1;
        logic       cap2;
        logic       wr0;
        logic       wr1;
        logic       load_diff;
        logic       mul;
        logic       shift;
        logic       sq;
        logic       sqrt;
        logic       div_init;
        logic       div;
        logic       out_load;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [3:0] en;
        logic       norm_done;
        logic       sq_done;
        logic       sqrt_last;
        logic       div_last;
        logic       out_free;
    } t_status;

    function automatic logic [63:0] f_height(input int unsigned c, input int unsigned frac);
        logic [63:0] num;
        num = 64'(c) * 64'(c) * (64'd765 - 64'(2 * c));
        return ((num << frac) + HeightDen / 2) / HeightDen;
    endfunction

endpackage

@@ src/hnm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Height to normal map controller
// Sequences row store access, the per-normal arithmetic steps and the
// hand-off of each result item to the output register.
// ----------------------------------------------------------------------------
module hnm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hnm_pkg::t_status  i_status,
    output hnm_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);

    hnm_pkg::t_state r_state, n_state;
    logic [1:0]      r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_stall = 1'b1;
        case (r_state)
            hnm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_idx        = '0;
                    n_state      = hnm_pkg::ST_RD0;
                end
            end
            hnm_pkg::ST_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = hnm_pkg::ST_RD1;
            end
            hnm_pkg::ST_RD1: begin
                o_cmd.rd1  = 1'b1;
                o_cmd.cap0 = 1'b1;
                n_state    = hnm_pkg::ST_RD2;
            end
            hnm_pkg::ST_RD2: begin
                o_cmd.cap1 = 1'b1;
                n_state    = hnm_pkg::ST_RD3;
            end
            hnm_pkg::ST_RD3: begin
                o_cmd.cap2 = 1'b1;
                n_state    = hnm_pkg::ST_WR0;
            end
            hnm_pkg::ST_WR0: begin
                o_cmd.wr0 = 1'b1;
                n_state   = hnm_pkg::ST_WR1;
            end
            hnm_pkg::ST_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = hnm_pkg::ST_PICK;
            end
            hnm_pkg::ST_PICK: begin
                if (i_status.en[r_idx]) begin
                    o_cmd.load_diff = 1'b1;
                    n_state         = hnm_pkg::ST_MUL;
                end else if (r_idx == hnm_pkg::EMIT_LAST_B) begin
                    n_state = hnm_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            hnm_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = hnm_pkg::ST_NORM;
            end
            hnm_pkg::ST_NORM: begin
                o_cmd.shift = 1'b1;
                if (i_status.norm_done) begin
                    n_state = hnm_pkg::ST_SQ;
                end
            end
            hnm_pkg::ST_SQ: begin
                o_cmd.sq = 1'b1;
                if (i_status.sq_done) begin
                    n_state = hnm_pkg::ST_SQRT;
                end
            end
            hnm_pkg::ST_SQRT: begin
                o_cmd.sqrt = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = hnm_pkg::ST_DIVI;
                end
            end
            hnm_pkg::ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = hnm_pkg::ST_DIV;
            end
            hnm_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = hnm_pkg::ST_OUT;
                end
            end
            hnm_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_idx == hnm_pkg::EMIT_LAST_B) begin
                        n_state = hnm_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = hnm_pkg::ST_PICK;
                    end
                end
            end
            default: begin
                n_state = hnm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/hnm_datapath.sv @@
// ----------------------------------------------------------------------------
// Height to normal map datapath
// Configuration registers, height table, row stores, pixel window, counters,
// the shared normalizer (scale, square sum, square root, divide) and the
// output register.
// ----------------------------------------------------------------------------
module hnm_datapath #(
    parameter int MAX_WIDTH        = hnm_pkg::MAX_WIDTH_DEF,
    parameter int HEIGHT_FRAC_BITS = hnm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hnm_pkg::t_cmd                     i_cmd,
    output hnm_pkg::t_status                  o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [hnm_pkg::COV_W-1:0]         i_coverage,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [hnm_pkg::NRM_W-1:0]         o_normal_x,
    output logic [hnm_pkg::NRM_W-1:0]         o_normal_y,
    output logic [hnm_pkg::NRM_W-1:0]         o_normal_z,
    output logic [hnm_pkg::COL_W-1:0]         o_column,
    output logic [hnm_pkg::ROW_W-1:0]         o_line,
    output logic                              o_last_of_run,
    output logic                              o_image_done
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CWW  = (AW + 1 > hnm_pkg::WIDTH_W) ? AW + 1 : hnm_pkg::WIDTH_W;
    localparam int HW   = HEIGHT_FRAC_BITS + 1;
    localparam int AXW  = HW + hnm_pkg::STEEP_W;
    localparam int RW   = hnm_pkg::ROW_W;
    localparam int OPW  = hnm_pkg::OP_W;
    localparam int SQW  = hnm_pkg::SQ_W;
    localparam int SMW  = hnm_pkg::SUM_W;
    localparam int DW   = hnm_pkg::DIV_W;
    localparam int QW   = hnm_pkg::Q_W;

    // Configuration
    logic [hnm_pkg::WIDTH_W-1:0] r_cfg_width;
    logic [RW-1:0]               r_cfg_height;
    logic [hnm_pkg::STEEP_W-1:0] r_steep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= hnm_pkg::WIDTH_RST;
            r_cfg_height <= hnm_pkg::HEIGHT_RST;
            r_steep      <= hnm_pkg::STEEP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hnm_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[hnm_pkg::WIDTH_W-1:0];
                hnm_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                hnm_pkg::CFG_STEEPNESS:    r_steep      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Height table
    logic [HW-1:0] w_height_table [256];

    for (genvar g = 0; g < 256; g++) begin : g_height
        localparam logic [HW-1:0] HVal = HW'(hnm_pkg::f_height(g, HEIGHT_FRAC_BITS));
        assign w_height_table[g] = HVal;
    end

    // Position and counters
    logic [AW-1:0]  r_col_cnt, r_cc;
    logic [RW-1:0]  r_row_cnt, r_cr;
    logic           r_lc;
    logic [3:0]     r_en;
    logic [HW-1:0]  r_win [3];
    logic [CWW-1:0] w_cw;
    logic [RW-1:0]  w_hh;
    logic [AW-1:0]  w_cc;
    logic [RW-1:0]  w_cr;
    logic           w_lc, w_lr;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_cw = CWW'(1);
        end else if (CWW'(r_cfg_width) > CWW'(MAX_WIDTH)) begin
            w_cw = CWW'(MAX_WIDTH);
        end else begin
            w_cw = CWW'(r_cfg_width);
        end
        w_hh = (r_cfg_height == '0) ? RW'(1) : r_cfg_height;
        w_cc = (CWW'(r_col_cnt) >= w_cw) ? AW'(w_cw - CWW'(1)) : r_col_cnt;
        w_cr = (r_row_cnt >= w_hh) ? w_hh - RW'(1) : r_row_cnt;
        w_lc = (CWW'(w_cc) == w_cw - CWW'(1));
        w_lr = (w_cr == w_hh - RW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_win[0]  <= '0;
            r_win[1]  <= '0;
            r_win[2]  <= '0;
            r_en      <= '0;
        end else if (i_cmd.accept) begin
            r_win[2] <= r_win[1];
            r_win[1] <= r_win[0];
            r_win[0] <= w_height_table[i_coverage];
            r_en     <= {w_lr && w_lc, w_lr && (w_cc != '0),
                         (w_cr != '0) && w_lc, (w_cr != '0) && (w_cc != '0)};
            if (w_lc) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_lr ? '0 : w_cr + RW'(1);
            end else begin
                r_col_cnt <= w_cc + AW'(1);
                r_row_cnt <= w_cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cc <= w_cc;
            r_cr <= w_cr;
            r_lc <= w_lc;
        end
    end

    // Row stores
    logic [HW-1:0] r_prev_mem  [MAX_WIDTH];
    logic [HW-1:0] r_older_mem [MAX_WIDTH];
    logic [HW-1:0] r_prev_q, r_older_q;
    logic [HW-1:0] r_pa, r_pb, r_oa1, r_oa, r_ob;
    logic [AW-1:0] w_a, w_a1, w_prev_raddr, w_older_raddr, w_waddr;
    logic          w_we;
    logic [HW-1:0] w_prev_wdata, w_older_wdata;

    assign w_a           = r_cc - AW'(1);
    assign w_a1          = r_cc - AW'(2);
    assign w_prev_raddr  = i_cmd.rd0 ? w_a : r_cc;
    assign w_older_raddr = i_cmd.rd0 ? w_a1 : (i_cmd.rd1 ? w_a : r_cc);
    assign w_we          = (i_cmd.wr0 && (r_cc != '0)) || (i_cmd.wr1 && r_lc);
    assign w_waddr       = i_cmd.wr0 ? w_a : r_cc;
    assign w_prev_wdata  = i_cmd.wr0 ? r_win[1] : r_win[0];
    assign w_older_wdata = i_cmd.wr0 ? r_pa : r_pb;

    always_ff @(posedge i_clk) begin
        r_prev_q  <= r_prev_mem[w_prev_raddr];
        r_older_q <= r_older_mem[w_older_raddr];
        if (w_we) begin
            r_prev_mem[w_waddr]  <= w_prev_wdata;
            r_older_mem[w_waddr] <= w_older_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap0) begin
            r_pa  <= r_prev_q;
            r_oa1 <= r_older_q;
        end
        if (i_cmd.cap1) begin
            r_pb <= r_prev_q;
            r_oa <= r_older_q;
        end
        if (i_cmd.cap2) begin
            r_ob <= r_older_q;
        end
    end

    // Operand selection for one normal
    logic [HW-1:0] w_l, w_r, w_t, w_b;
    logic [AW-1:0] w_col;
    logic [RW-1:0] w_row;
    logic          w_last;
    logic          w_cr_one, w_cr_zero, w_a_pos;

    assign w_cr_one  = (r_cr == RW'(1));
    assign w_cr_zero = (r_cr == '0);
    assign w_a_pos   = (w_a != '0) && (r_cc != '0);

    always_comb begin
        case (i_cmd.idx)
            hnm_pkg::EMIT_UP_A: begin
                w_l    = w_a_pos ? r_oa1 : r_pa;
                w_r    = r_pb;
                w_t    = w_cr_one ? r_pa : r_oa;
                w_b    = r_win[1];
                w_col  = w_a;
                w_row  = r_cr - RW'(1);
                w_last = (r_en[3:1] == '0);
            end
            hnm_pkg::EMIT_UP_B: begin
                w_l    = (r_cc != '0) ? r_pa : r_pb;
                w_r    = r_pb;
                w_t    = w_cr_one ? r_pb : r_ob;
                w_b    = r_win[0];
                w_col  = r_cc;
                w_row  = r_cr - RW'(1);
                w_last = (r_en[3:2] == '0);
            end
            hnm_pkg::EMIT_LAST_A: begin
                w_l    = w_a_pos ? r_win[2] : r_win[1];
                w_r    = r_win[0];
                w_t    = w_cr_zero ? r_win[1] : r_pa;
                w_b    = r_win[1];
                w_col  = w_a;
                w_row  = r_cr;
                w_last = !r_en[3];
            end
            default: begin
                w_l    = (r_cc != '0) ? r_win[1] : r_win[0];
                w_r    = r_win[0];
                w_t    = w_cr_zero ? r_win[0] : r_pb;
                w_b    = r_win[0];
                w_col  = r_cc;
                w_row  = r_cr;
                w_last = 1'b1;
            end
        endcase
    end

    // Normalizer
    logic [HW-1:0]  r_dxm, r_dym;
    logic           r_xneg, r_yneg;
    logic [AXW-1:0] r_ax, r_ay, r_k;
    logic [AW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_last, r_done;
    logic           w_big;
    logic [1:0]     r_sqc;
    logic [OPW-1:0] w_op;
    logic [SQW-1:0] r_sq;
    logic [SMW-1:0] r_sum, r_n, r_res, r_bit, w_trial;
    logic [hnm_pkg::ROOT_W-1:0] w_len;
    logic [hnm_pkg::U_W-1:0]    w_u [3];
    logic [DW-1:0]  r_rem [3];
    logic [DW-1:0]  r_dsh;
    logic [QW-1:0]  r_q [3];
    logic [2:0]     r_divc;

    assign w_big = (64'(r_ax) >= hnm_pkg::NormLimit) || (64'(r_ay) >= hnm_pkg::NormLimit)
                || (64'(r_k) >= hnm_pkg::NormLimit);

    always_comb begin
        case (r_sqc)
            2'd0:    w_op = OPW'(r_ax);
            2'd1:    w_op = OPW'(r_ay);
            default: w_op = OPW'(r_k);
        endcase
    end

    assign w_trial = r_res + r_bit;
    assign w_len   = hnm_pkg::ROOT_W'(r_res);
    assign w_u[0]  = r_xneg ? hnm_pkg::U_W'(w_len) + hnm_pkg::U_W'(OPW'(r_ax))
                            : hnm_pkg::U_W'(w_len) - hnm_pkg::U_W'(OPW'(r_ax));
    assign w_u[1]  = r_yneg ? hnm_pkg::U_W'(w_len) + hnm_pkg::U_W'(OPW'(r_ay))
                            : hnm_pkg::U_W'(w_len) - hnm_pkg::U_W'(OPW'(r_ay));
    assign w_u[2]  = hnm_pkg::U_W'(w_len) + hnm_pkg::U_W'(OPW'(r_k));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            r_dxm  <= (w_r >= w_l) ? w_r - w_l : w_l - w_r;
            r_xneg <= (w_r < w_l);
            r_dym  <= (w_b >= w_t) ? w_b - w_t : w_t - w_b;
            r_yneg <= (w_b < w_t);
            r_col  <= w_col;
            r_row  <= w_row;
            r_last <= w_last;
            r_done <= (i_cmd.idx == hnm_pkg::EMIT_LAST_B);
        end
        if (i_cmd.mul) begin
            r_ax <= r_dxm * r_steep;
            r_ay <= r_dym * r_steep;
            r_k  <= AXW'(1) << (HEIGHT_FRAC_BITS + 9);
        end
        if (i_cmd.shift) begin
            r_sqc <= '0;
            if (w_big) begin
                r_ax <= r_ax >> 1;
                r_ay <= r_ay >> 1;
                r_k  <= r_k >> 1;
            end
        end
        if (i_cmd.sq) begin
            r_sq  <= w_op * w_op;
            r_sum <= (r_sqc == '0) ? '0 : r_sum + SMW'(r_sq);
            r_sqc <= r_sqc + 2'd1;
            if (r_sqc == 2'd3) begin
                r_n   <= r_sum + SMW'(r_sq);
                r_res <= '0;
                r_bit <= SMW'(1) << (SMW - 2);
            end
        end
        if (i_cmd.sqrt) begin
            if (r_n >= w_trial) begin
                r_n   <= r_n - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= (DW'(w_u[i]) << 8) - DW'(w_u[i]) + DW'(w_len);
                r_q[i]   <= '0;
            end
            r_dsh  <= DW'(w_len) << QW;
            r_divc <= 3'(QW - 1);
        end
        if (i_cmd.div) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[i] >= r_dsh) begin
                    r_rem[i]       <= r_rem[i] - r_dsh;
                    r_q[i][r_divc] <= 1'b1;
                end
            end
            r_dsh  <= r_dsh >> 1;
            r_divc <= r_divc - 3'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_normal_x    <= r_q[0];
            o_normal_y    <= r_q[1];
            o_normal_z    <= r_q[2];
            o_column      <= hnm_pkg::COL_W'(r_col);
            o_line        <= r_row;
            o_last_of_run <= r_last;
            o_image_done  <= r_done;
        end
    end

    assign o_status.en        = r_en;
    assign o_status.norm_done = !w_big;
    assign o_status.sq_done   = (r_sqc == 2'd3);
    assign o_status.sqrt_last = r_bit[0];
    assign o_status.div_last  = (r_divc == '0);
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

endmodule

@@ src/height_to_normal_map_core.sv @@
// ----------------------------------------------------------------------------
// Height to normal map core
// Turns a raster stream of blurred coverage bytes into encoded surface
// normals using central differences over a smoothstep height field.
//
// Input channel: i_in_valid / o_in_stall carry one coverage byte per item.
// Output channel: o_out_valid / i_out_stall carry one normal per item with
// its column, line, last_of_run and image_done flags. Results trail the
// input by one row and one column; the final row is emitted as it arrives.
// Each input item passes through row store reads, writes and result
// selection, then yields 0 to 4 normals, each computed through the bit-serial
// square root and the three-lane restoring divider.
// The next input item is taken while the last normal waits in the output
// register; a stalled output holds the controller once the next normal is
// ready. Reset returns the configuration to 1024 x 1024 with steepness 1.0
// and restarts at the first pixel; row stores are not cleared.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// by the user only while no item is in flight; this is not enforced.
// ----------------------------------------------------------------------------
module height_to_normal_map_core #(
    parameter int MAX_WIDTH        = hnm_pkg::MAX_WIDTH_DEF,
    parameter int HEIGHT_FRAC_BITS = hnm_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [hnm_pkg::COV_W-1:0]      i_coverage,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [hnm_pkg::NRM_W-1:0]      o_normal_x,
    output logic [hnm_pkg::NRM_W-1:0]      o_normal_y,
    output logic [hnm_pkg::NRM_W-1:0]      o_normal_z,
    output logic [hnm_pkg::COL_W-1:0]      o_column,
    output logic [hnm_pkg::ROW_W-1:0]      o_line,
    output logic                           o_last_of_run,
    output logic                           o_image_done
);

    hnm_pkg::t_cmd    w_cmd;
    hnm_pkg::t_status w_status;

    hnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    hnm_datapath #(
        .MAX_WIDTH        (MAX_WIDTH),
        .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_coverage    (i_coverage),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z),
        .o_column      (o_column),
        .o_line        (o_line),
        .o_last_of_run (o_last_of_run),
        .o_image_done  (o_image_done)
    );

endmodule

@@ src/hnm_checker.sv @@
// ----------------------------------------------------------------------------
// Height to normal map checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module hnm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [hnm_pkg::NRM_W-1:0] o_normal_x,
    input logic [hnm_pkg::NRM_W-1:0] o_normal_y,
    input logic [hnm_pkg::NRM_W-1:0] o_normal_z,
    input logic [hnm_pkg::COL_W-1:0] o_column,
    input logic [hnm_pkg::ROW_W-1:0] o_line,
    input logic                      o_last_of_run,
    input logic                      o_image_done
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_normal_x)
            && $stable(o_normal_y) && $stable(o_normal_z) && $stable(o_column)
            && $stable(o_line) && $stable(o_last_of_run) && $stable(o_image_done))
        else $error("output item changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_done |-> o_last_of_run)
        else $error("image end not marked as end of run");

    a_z_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normal_z >= 8'd128)
        else $error("normal points below the surface");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

endmodule

bind height_to_normal_map_core hnm_checker u_checker (.*);
